// File: rtl/core/fbdlp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fbdlp_pkg;

    // Fixed field widths of the item channels.
    localparam int FIELD_BUTTONS   = 4;
    localparam int FIELD_TIME_BITS = 32;
    localparam int FIELD_CNT_BITS  = 16;

    // Defaults for the top-level parameters.
    localparam int BUTTON_COUNT_DEF     = 4;
    localparam int PRESS_COUNT_BITS_DEF = 16;
    localparam int TIME_BITS_DEF        = 32;

    // Lockout counter saturates at this value.
    localparam int          LOCKOUT_BITS = 10;
    localparam logic [9:0]  LOCKOUT_SAT  = 10'd1000;

    // Bit position of the hash button.
    localparam int HASH_IDX = 2;

    // Configuration registers.
    localparam int          CFG_ADDR_BITS  = 3;
    localparam logic [15:0] LONG_PRESS_RST = 16'd1000;
    localparam logic [7:0]  LOCKOUT_RST    = 8'd2;

    typedef enum logic {
        REG_LONG_PRESS = 1'b0,
        REG_LOCKOUT    = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [FIELD_BUTTONS-1:0]   buttons_raw;
        logic [FIELD_TIME_BITS-1:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_BUTTONS-1:0]  pressed_mask;
        logic [FIELD_BUTTONS-1:0]  press_edge_mask;
        logic                      hash_long_press;
        logic [FIELD_CNT_BITS-1:0] up_press_count;
        logic [FIELD_CNT_BITS-1:0] down_press_count;
        logic [FIELD_CNT_BITS-1:0] hash_press_count;
        logic [FIELD_CNT_BITS-1:0] star_press_count;
    } t_out_item;

endpackage

`default_nettype wire

// File: rtl/core/four_button_debounce_long_press_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    i_in_data  (t_in_item)
// output    out        o_out_valid / i_out_stall  o_out_data (t_out_item)
// config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One item per cycle is accepted into the input register while o_in_stall is
// low. Its result passes from the input register into the result register,
// where it is offered on o_out_data. The debounce state is updated once per
// item as it leaves the input register. Synchronous active-low reset clears
// the valid flags and all debounce state and loads the register defaults. A
// stalled result holds the pipeline; the input register still takes an item
// while it is empty or the result register is free to move.
module four_button_debounce_long_press_unit #(
    parameter int BUTTON_COUNT     = fbdlp_pkg::BUTTON_COUNT_DEF,
    parameter int PRESS_COUNT_BITS = fbdlp_pkg::PRESS_COUNT_BITS_DEF,
    parameter int TIME_BITS        = fbdlp_pkg::TIME_BITS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_stall,
    input  fbdlp_pkg::t_in_item                  i_in_data,
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output fbdlp_pkg::t_out_item                 o_out_data,
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [fbdlp_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  wire  [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import fbdlp_pkg::*;

    localparam int  NB       = (BUTTON_COUNT < FIELD_BUTTONS) ? BUTTON_COUNT : FIELD_BUTTONS;
    localparam bit  HAS_HASH = (NB > HASH_IDX);

    // Configuration registers.
    logic [15:0] r_long_press;
    logic [7:0]  r_lockout;

    // Pipeline registers.
    logic      r_in_vld;
    t_in_item  r_in;
    logic      r_out_vld;
    t_out_item r_out;
    t_out_item n_out;

    // Debounce state.
    logic [FIELD_BUTTONS-1:0]    r_lvl;
    logic [FIELD_BUTTONS-1:0]    n_lvl;
    logic [LOCKOUT_BITS-1:0]     r_lock [NB];
    logic [LOCKOUT_BITS-1:0]     n_lock [NB];
    logic [PRESS_COUNT_BITS-1:0] r_cnt  [NB];
    logic [PRESS_COUNT_BITS-1:0] n_cnt  [NB];
    logic [TIME_BITS-1:0]        r_hold_start;
    logic [TIME_BITS-1:0]        n_hold_start;
    logic                        r_hold_vld;
    logic                        n_hold_vld;
    logic                        r_flag;
    logic                        n_flag;

    logic [FIELD_BUTTONS-1:0]  w_press;
    logic [FIELD_BUTTONS-1:0]  w_release;
    logic [TIME_BITS-1:0]      w_now;
    logic [TIME_BITS-1:0]      w_held;
    logic [FIELD_CNT_BITS-1:0] w_cnt_out [FIELD_BUTTONS];
    logic                      w_adv;
    logic                      w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press <= LONG_PRESS_RST;
            r_lockout    <= LOCKOUT_RST;
        end else if (w_cfg_wr) begin
            case (t_reg_idx'(paddr[2]))
                REG_LONG_PRESS: r_long_press <= pwdata[15:0];
                REG_LOCKOUT:    r_lockout    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[2]))
            REG_LONG_PRESS: prdata = {16'd0, r_long_press};
            REG_LOCKOUT:    prdata = {24'd0, r_lockout};
            default:        prdata = 32'd0;
        endcase
    end

    // The result register moves when it is empty or being taken.
    assign w_adv       = !r_out_vld || !i_out_stall;
    assign o_in_stall  = r_in_vld && !w_adv;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    assign w_now = TIME_BITS'(r_in.now_ms);

    // Per-button lockout debounce.
    always_comb begin
        n_lvl     = r_lvl;
        w_press   = '0;
        w_release = '0;
        for (int i = 0; i < NB; i++) begin
            n_lock[i] = r_lock[i];
            n_cnt[i]  = r_cnt[i];
            if ((r_lvl[i] != !r_in.buttons_raw[i]) &&
                (r_lock[i] > {{(LOCKOUT_BITS-8){1'b0}}, r_lockout})) begin
                n_lvl[i]  = !r_in.buttons_raw[i];
                n_lock[i] = '0;
                if (!r_in.buttons_raw[i]) begin
                    w_press[i] = 1'b1;
                    n_cnt[i]   = r_cnt[i] + 1'b1;
                end else begin
                    w_release[i] = 1'b1;
                end
            end else if (r_lock[i] < LOCKOUT_SAT) begin
                n_lock[i] = r_lock[i] + 1'b1;
            end
        end
    end

    // Hash hold timer and long-press flag.
    always_comb begin
        n_hold_start = r_hold_start;
        n_hold_vld   = r_hold_vld;
        n_flag       = r_flag;
        if (w_press[HASH_IDX]) begin
            n_hold_start = w_now;
            n_hold_vld   = 1'b1;
        end else if (w_release[HASH_IDX]) begin
            n_hold_start = '0;
            n_hold_vld   = 1'b0;
            n_flag       = 1'b0;
        end
        w_held = w_now - n_hold_start;
        if (HAS_HASH && n_lvl[HASH_IDX] && !n_flag && n_hold_vld &&
            (w_held > TIME_BITS'(r_long_press))) begin
            n_flag = 1'b1;
        end
    end

    for (genvar g = 0; g < FIELD_BUTTONS; g++) begin : g_cnt_out
        if (g < NB) begin : g_on
            assign w_cnt_out[g] = FIELD_CNT_BITS'(n_cnt[g]);
        end else begin : g_off
            assign w_cnt_out[g] = '0;
        end
    end

    always_comb begin
        n_out.pressed_mask     = n_lvl;
        n_out.press_edge_mask  = w_press;
        n_out.hash_long_press  = n_flag;
        n_out.up_press_count   = w_cnt_out[0];
        n_out.down_press_count = w_cnt_out[1];
        n_out.hash_press_count = w_cnt_out[2];
        n_out.star_press_count = w_cnt_out[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl        <= '0;
            r_hold_start <= '0;
            r_hold_vld   <= 1'b0;
            r_flag       <= 1'b0;
            for (int i = 0; i < NB; i++) begin
                r_lock[i] <= '0;
                r_cnt[i]  <= '0;
            end
        end else if (r_in_vld && w_adv) begin
            r_lvl        <= n_lvl;
            r_hold_start <= n_hold_start;
            r_hold_vld   <= n_hold_vld;
            r_flag       <= n_flag;
            for (int i = 0; i < NB; i++) begin
                r_lock[i] <= n_lock[i];
                r_cnt[i]  <= n_cnt[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_vld) begin
            r_out <= n_out;
        end
    end

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_vld && r_out_vld && i_out_stall))
        else $error("input stalled without a blocked item in the pipeline");

    a_edge_implies_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.press_edge_mask & ~o_out_data.pressed_mask) == '0))
        else $error("press edge reported for a released button");

    a_long_press_needs_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flag |-> (r_hold_vld && r_lvl[HASH_IDX]))
        else $error("long press flag set without an active hash hold");

    a_lockout_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lock[0] <= LOCKOUT_SAT)
        else $error("lockout counter ran past its saturation value");

endmodule

`default_nettype wire
